[rtl/sld_pkg.sv]
// Shared types, codes and the text byte handling function of the deframer.
package sld_pkg;

    // Receive modes.
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SYNC    = 3'd1;
    localparam logic [2:0] M_LEN_HI  = 3'd2;
    localparam logic [2:0] M_LEN_LO  = 3'd3;
    localparam logic [2:0] M_PAYLOAD = 3'd4;
    localparam logic [2:0] M_TEXT    = 3'd5;

    // Result kinds.
    localparam logic [2:0] K_TEXT     = 3'd0;
    localparam logic [2:0] K_PAYLOAD  = 3'd1;
    localparam logic [2:0] K_LINE_END = 3'd2;
    localparam logic [2:0] K_LINE_OVF = 3'd3;
    localparam logic [2:0] K_ACCEPT   = 3'd4;
    localparam logic [2:0] K_REJECT   = 3'd5;
    localparam logic [2:0] K_LEN_ZERO = 3'd6;
    localparam logic [2:0] K_LEN_BIG  = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_MAX_TEXT    = 2'd1;
    localparam logic [1:0] REG_MAGIC       = 2'd2;

    // Byte constants.
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // Reset values of the configuration registers.
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;
    localparam logic [11:0] MAX_TEXT_RESET    = 12'd512;
    localparam logic [31:0] MAGIC_RESET       = 32'h56494F43;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       last_of_step;
    } result_t;

    // Results of one input item: up to two, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic       emit;
        result_t    res;
        logic [11:0] line_count;
        logic [2:0]  mode;
    } text_out_t;

    function automatic text_out_t text_step(input logic [7:0] b,
                                            input logic [11:0] lc,
                                            input logic [11:0] max_len);
        text_out_t r;
        r.emit = 1'b0;
        r.res.kind = K_TEXT;
        r.res.data_byte = 8'd0;
        r.res.last_of_step = 1'b0;
        r.line_count = lc;
        r.mode = M_TEXT;
        if (b == CH_LF) begin
            r.emit = (lc != 12'd0);
            r.res.kind = K_LINE_END;
            r.line_count = 12'd0;
            r.mode = M_IDLE;
        end else if (b == CH_CR) begin
            r.mode = M_TEXT;
        end else if (({1'b0, lc} + 13'd1) > {1'b0, max_len}) begin
            r.emit = 1'b1;
            r.res.kind = K_LINE_OVF;
            r.line_count = 12'd0;
            r.mode = M_IDLE;
        end else begin
            r.emit = 1'b1;
            r.res.kind = K_TEXT;
            r.res.data_byte = b;
            r.line_count = lc + 12'd1;
            r.mode = M_TEXT;
        end
        return r;
    endfunction

endpackage

[rtl/sld_step.sv]
// Receive state, configuration registers and the per-byte decode logic.
module sld_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    input  logic           take,
    input  logic [7:0]     rx_byte,
    output sld_pkg::push_t push
);

    logic [15:0] max_payload_reg;
    logic [11:0] max_text_reg;
    logic [31:0] magic_reg;

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [11:0] line_reg, line_next;
    logic        match_reg, match_next;

    sld_pkg::text_out_t t_first;
    sld_pkg::text_out_t t_second;
    sld_pkg::result_t   r0;
    sld_pkg::result_t   r1;
    logic [1:0]  n;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic [7:0]  magic_byte;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_payload_reg <= sld_pkg::MAX_PAYLOAD_RESET;
            max_text_reg    <= sld_pkg::MAX_TEXT_RESET;
            magic_reg       <= sld_pkg::MAGIC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                sld_pkg::REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[15:0];
                sld_pkg::REG_MAX_TEXT:    max_text_reg    <= cfg_data[11:0];
                sld_pkg::REG_MAGIC:       magic_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t_first  = sld_pkg::text_step(sld_pkg::SYNC_FIRST, line_reg, max_text_reg);
        t_second = sld_pkg::text_step(rx_byte,
                                      (mode_reg == sld_pkg::M_SYNC) ? t_first.line_count
                                                                    : line_reg,
                                      max_text_reg);
        len_full = {len_reg[15:8], rx_byte};
        cnt_inc  = cnt_reg + 16'd1;
        case (cnt_reg[1:0])
            2'd0:    magic_byte = magic_reg[31:24];
            2'd1:    magic_byte = magic_reg[23:16];
            2'd2:    magic_byte = magic_reg[15:8];
            default: magic_byte = magic_reg[7:0];
        endcase

        mode_next  = mode_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        match_next = match_reg;
        n  = 2'd0;
        r0 = '0;
        r1 = '0;

        case (mode_reg)
            sld_pkg::M_SYNC: begin
                if (rx_byte == sld_pkg::SYNC_SECOND) begin
                    len_next  = 16'd0;
                    cnt_next  = 16'd0;
                    mode_next = sld_pkg::M_LEN_HI;
                end else begin
                    // The held AA always yields a result; the current byte only
                    // follows it if the line survived.
                    r0 = t_first.res;
                    n  = 2'd1;
                    if (t_first.mode == sld_pkg::M_TEXT) begin
                        line_next = t_second.line_count;
                        mode_next = t_second.mode;
                        if (t_second.emit) begin
                            r1 = t_second.res;
                            n  = 2'd2;
                        end
                    end else begin
                        line_next = t_first.line_count;
                        mode_next = t_first.mode;
                    end
                end
            end
            sld_pkg::M_LEN_HI: begin
                len_next  = {rx_byte, 8'd0};
                mode_next = sld_pkg::M_LEN_LO;
            end
            sld_pkg::M_LEN_LO: begin
                len_next = len_full;
                if (len_full == 16'd0) begin
                    r0.kind   = sld_pkg::K_LEN_ZERO;
                    n         = 2'd1;
                    mode_next = sld_pkg::M_IDLE;
                end else if (len_full > max_payload_reg) begin
                    r0.kind   = sld_pkg::K_LEN_BIG;
                    n         = 2'd1;
                    len_next  = 16'd0;
                    mode_next = sld_pkg::M_IDLE;
                end else begin
                    cnt_next   = 16'd0;
                    match_next = 1'b1;
                    mode_next  = sld_pkg::M_PAYLOAD;
                end
            end
            sld_pkg::M_PAYLOAD: begin
                r0.kind      = sld_pkg::K_PAYLOAD;
                r0.data_byte = rx_byte;
                n            = 2'd1;
                if (cnt_reg[15:2] == 14'd0 && magic_byte != rx_byte) begin
                    match_next = 1'b0;
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg) begin
                    r1.kind   = (len_reg >= 16'd4 && match_next) ? sld_pkg::K_ACCEPT
                                                                : sld_pkg::K_REJECT;
                    n         = 2'd2;
                    len_next  = 16'd0;
                    cnt_next  = 16'd0;
                    mode_next = sld_pkg::M_IDLE;
                end
            end
            sld_pkg::M_TEXT: begin
                line_next = t_second.line_count;
                mode_next = t_second.mode;
                if (t_second.emit) begin
                    r0 = t_second.res;
                    n  = 2'd1;
                end
            end
            default: begin
                if (rx_byte == sld_pkg::SYNC_FIRST) begin
                    len_next  = 16'd0;
                    cnt_next  = 16'd0;
                    mode_next = sld_pkg::M_SYNC;
                end else begin
                    line_next = t_second.line_count;
                    mode_next = t_second.mode;
                    if (t_second.emit) begin
                        r0 = t_second.res;
                        n  = 2'd1;
                    end
                end
            end
        endcase

        if (n == 2'd1) begin
            r0.last_of_step = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last_of_step = 1'b1;
        end
        push.count  = take ? n : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= sld_pkg::M_IDLE;
            len_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
            line_reg  <= 12'd0;
            match_reg <= 1'b1;
        end else if (take) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            match_reg <= match_next;
        end
    end

endmodule

[rtl/sld_queue.sv]
// Four-entry result queue that takes up to two results and gives one per cycle while out_ready is high.
module sld_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  sld_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output sld_pkg::result_t head
);

    sld_pkg::result_t entry_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] fill_reg;
    logic       pop;

    assign out_valid = (fill_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign head      = entry_reg[rd_reg];
    // Room for the worst case of two results from one item.
    assign room      = (fill_reg <= 3'd2);

    always_ff @(posedge clk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg   <= 2'd0;
            rd_reg   <= 2'd0;
            fill_reg <= 3'd0;
        end else begin
            wr_reg   <= wr_reg + push.count;
            rd_reg   <= rd_reg + {1'b0, pop};
            fill_reg <= fill_reg + {1'b0, push.count} - {2'b00, pop};
        end
    end

endmodule

[rtl/sync_length_frame_text_line_deframer_top.sv]
// Top level of the serial byte deframer for binary frames and text lines.
//
// One received byte is taken per cycle whenever the four-entry result queue
// has room for two results; each byte is decoded in the cycle it is accepted
// and yields zero, one or two results, which leave one per cycle from the
// queue head while out_ready is high. A byte that gives one result or none
// sustains one item per cycle; a byte that gives two (a payload byte closing a
// frame, or a broken sync pair) puts a second result into the queue, which the
// queue absorbs while the output side keeps taking results. Configuration
// writes take effect on the next byte.
module sync_length_frame_text_line_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last_of_step,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sld_pkg::push_t   push;
    sld_pkg::result_t head;
    logic             take;

    assign take = in_valid && in_ready;

    sld_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .rx_byte   (rx_byte),
        .push      (push)
    );

    sld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign data_byte    = head.data_byte;
    assign last_of_step = head.last_of_step;

endmodule

[tb/sync_length_frame_text_line_deframer_top_tb.sv]
// Self-checking testbench for the serial byte deframer of binary frames and text lines.
`timescale 1ns / 1ps

module sync_length_frame_text_line_deframer_top_tb;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 500;

    typedef struct packed {
        logic             is_cfg;
        logic [1:0]       reg_idx;
        logic [31:0]      value;
        logic             from_model;
        logic [1:0]       n_typed;
        sld_pkg::result_t r0;
        sld_pkg::result_t r1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last_of_step;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predictor copy of the registers and of the receive state.
    logic [15:0]      max_payload_q;
    logic [11:0]      max_text_q;
    logic [31:0]      magic_q;
    logic [2:0]       mode_q;
    logic [15:0]      frame_len_q;
    logic [15:0]      payload_cnt_q;
    logic [11:0]      line_cnt_q;
    logic             magic_ok_q;
    sld_pkg::result_t step_buf [0:1];
    int               step_n;
    sld_pkg::result_t deframed_q [$];

    stim_row_t   directed_rows [$];
    logic [7:0]  phase_bytes [$];

    int          error_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          settings_used = 0;
    int          cycle_count = 0;
    int          kind_seen [0:7];
    bit          sender_gaps = 1'b1;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          roll;

    sync_length_frame_text_line_deframer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_of_step (last_of_step),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic add_result(input logic [2:0] k, input logic [7:0] d);
        sld_pkg::result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.last_of_step = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endtask

    task automatic line_byte(input logic [7:0] b);
        if (b == sld_pkg::CH_LF)
        begin
            if (line_cnt_q != 12'd0)
                add_result(sld_pkg::K_LINE_END, 8'd0);
            line_cnt_q = 12'd0;
            mode_q     = sld_pkg::M_IDLE;
        end
        else if (b == sld_pkg::CH_CR)
        begin
            mode_q = sld_pkg::M_TEXT;
        end
        else if ({1'b0, line_cnt_q} + 13'd1 > {1'b0, max_text_q})
        begin
            add_result(sld_pkg::K_LINE_OVF, 8'd0);
            line_cnt_q = 12'd0;
            mode_q     = sld_pkg::M_IDLE;
        end
        else
        begin
            add_result(sld_pkg::K_TEXT, b);
            line_cnt_q = line_cnt_q + 12'd1;
            mode_q     = sld_pkg::M_TEXT;
        end
    endtask

    // Works out the results of one received byte into step_buf.
    task automatic deframe_byte(input logic [7:0] b);
        int sh;
        step_n = 0;
        case (mode_q)
            sld_pkg::M_SYNC:
            begin
                if (b == sld_pkg::SYNC_SECOND)
                begin
                    frame_len_q   = 16'd0;
                    payload_cnt_q = 16'd0;
                    mode_q        = sld_pkg::M_LEN_HI;
                end
                else
                begin
                    // The held sync byte goes out as text first; if it overflowed
                    // the line, the current byte is lost.
                    line_byte(sld_pkg::SYNC_FIRST);
                    if (mode_q == sld_pkg::M_TEXT)
                        line_byte(b);
                end
            end
            sld_pkg::M_LEN_HI:
            begin
                frame_len_q = {b, 8'h00};
                mode_q      = sld_pkg::M_LEN_LO;
            end
            sld_pkg::M_LEN_LO:
            begin
                frame_len_q = frame_len_q | {8'h00, b};
                if (frame_len_q == 16'd0)
                begin
                    add_result(sld_pkg::K_LEN_ZERO, 8'd0);
                    mode_q = sld_pkg::M_IDLE;
                end
                else if (frame_len_q > max_payload_q)
                begin
                    add_result(sld_pkg::K_LEN_BIG, 8'd0);
                    frame_len_q = 16'd0;
                    mode_q      = sld_pkg::M_IDLE;
                end
                else
                begin
                    payload_cnt_q = 16'd0;
                    magic_ok_q    = 1'b1;
                    mode_q        = sld_pkg::M_PAYLOAD;
                end
            end
            sld_pkg::M_PAYLOAD:
            begin
                add_result(sld_pkg::K_PAYLOAD, b);
                if (payload_cnt_q < 16'd4)
                begin
                    sh = 24 - 8 * int'(payload_cnt_q);
                    if (magic_q[sh +: 8] != b)
                        magic_ok_q = 1'b0;
                end
                payload_cnt_q = payload_cnt_q + 16'd1;
                if (payload_cnt_q >= frame_len_q)
                begin
                    add_result((frame_len_q >= 16'd4 && magic_ok_q) ? sld_pkg::K_ACCEPT
                                                                    : sld_pkg::K_REJECT,
                               8'd0);
                    frame_len_q   = 16'd0;
                    payload_cnt_q = 16'd0;
                    mode_q        = sld_pkg::M_IDLE;
                end
            end
            sld_pkg::M_TEXT:
            begin
                line_byte(b);
            end
            default:
            begin
                if (b == sld_pkg::SYNC_FIRST)
                begin
                    frame_len_q   = 16'd0;
                    payload_cnt_q = 16'd0;
                    mode_q        = sld_pkg::M_SYNC;
                end
                else
                begin
                    line_byte(b);
                end
            end
        endcase
    endtask

    task automatic push_step();
        sld_pkg::result_t r;
        for (int i = 0; i < step_n; i++)
        begin
            r = step_buf[i];
            r.last_of_step = (i == step_n - 1);
            deframed_q.push_back(r);
        end
    endtask

    task automatic send_item(input stim_row_t row);
        int gap;
        int g;
        gap = 0;
        if (sender_gaps)
        begin
            g = $urandom_range(0, 99);
            if (g >= 92)
                gap = $urandom_range(8, 30);
            else if (g >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= row.value[7:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        deframe_byte(row.value[7:0]);
        // Typed rows keep the predictor state moving but supply their own results.
        if (!row.from_model)
        begin
            step_n      = row.n_typed;
            step_buf[0] = row.r0;
            step_buf[1] = row.r1;
        end
        push_step();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        // A byte that gives no result may still be in flight.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            sld_pkg::REG_MAX_PAYLOAD: max_payload_q = val[15:0];
            sld_pkg::REG_MAX_TEXT:    max_text_q    = val[11:0];
            sld_pkg::REG_MAGIC:       magic_q       = val;
            default:                  ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] pl, input logic [11:0] tx,
                                 input logic [31:0] mg);
        wait_idle();
        write_register(sld_pkg::REG_MAX_PAYLOAD, {16'd0, pl});
        write_register(sld_pkg::REG_MAX_TEXT, {20'd0, tx});
        write_register(sld_pkg::REG_MAGIC, mg);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic stim_row_t quiet_row(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.value = {24'd0, b};
        return row;
    endfunction

    function automatic stim_row_t one_row(input logic [7:0] b, input logic [2:0] k,
                                          input logic [7:0] d);
        stim_row_t row;
        row = quiet_row(b);
        row.n_typed      = 2'd1;
        row.r0.kind      = k;
        row.r0.data_byte = d;
        return row;
    endfunction

    function automatic stim_row_t two_row(input logic [7:0] b,
                                          input logic [2:0] k0, input logic [7:0] d0,
                                          input logic [2:0] k1, input logic [7:0] d1);
        stim_row_t row;
        row = one_row(b, k0, d0);
        row.n_typed      = 2'd2;
        row.r1.kind      = k1;
        row.r1.data_byte = d1;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] v);
        stim_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = v;
        return row;
    endfunction

    // Mostly well-formed frames and lines with random content, plus broken
    // sync pairs, bad lengths and loose noise bytes.
    task automatic build_phase_bytes();
        int pick;
        int len;
        int bad_pos;
        logic [7:0]  b;
        logic [15:0] flen;
        logic        magic_good;
        phase_bytes.delete();
        while (phase_bytes.size() < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    len = $urandom_range(4, 12);
                else if (pick < 75)
                    len = $urandom_range(1, 3);
                else if (pick < 98)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(64, 300);
                if (len > int'(max_payload_q))
                    len = int'(max_payload_q);
                flen       = 16'(len);
                magic_good = ($urandom_range(0, 3) != 0);
                bad_pos    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1;
                phase_bytes.push_back(sld_pkg::SYNC_FIRST);
                phase_bytes.push_back(sld_pkg::SYNC_SECOND);
                phase_bytes.push_back(flen[15:8]);
                phase_bytes.push_back(flen[7:0]);
                for (int i = 0; i < len; i++)
                begin
                    if (magic_good && i < 4)
                    begin
                        b = magic_q[8 * (3 - i) +: 8];
                        if (i == bad_pos)
                            b = b ^ (8'h01 << $urandom_range(0, 7));
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    phase_bytes.push_back(b);
                end
            end
            else if (pick < 48)
            begin
                if ($urandom_range(0, 1) == 0 || max_payload_q == 16'hFFFF)
                begin
                    len = 0;
                end
                else
                begin
                    len = int'(max_payload_q) + $urandom_range(1, 300);
                    if (len > 65535)
                        len = 65535;
                end
                flen = 16'(len);
                phase_bytes.push_back(sld_pkg::SYNC_FIRST);
                phase_bytes.push_back(sld_pkg::SYNC_SECOND);
                phase_bytes.push_back(flen[15:8]);
                phase_bytes.push_back(flen[7:0]);
            end
            else if (pick < 80)
            begin
                if (max_text_q < 12'd20)
                    len = $urandom_range(0, int'(max_text_q) + 2);
                else
                    len = $urandom_range(0, 20);
                if ($urandom_range(0, 9) == 0 && max_text_q <= 12'd64)
                    len = int'(max_text_q) + 1;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        b = sld_pkg::CH_CR;
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == sld_pkg::CH_LF)
                            b = 8'h61;
                    end
                    phase_bytes.push_back(b);
                end
                if ($urandom_range(0, 9) != 0)
                    phase_bytes.push_back(sld_pkg::CH_LF);
            end
            else if (pick < 90)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == sld_pkg::SYNC_SECOND)
                    b = 8'h56;
                phase_bytes.push_back(sld_pkg::SYNC_FIRST);
                phase_bytes.push_back(b);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 4))
                        0:       b = sld_pkg::SYNC_FIRST;
                        1:       b = sld_pkg::SYNC_SECOND;
                        2:       b = sld_pkg::CH_LF;
                        3:       b = sld_pkg::CH_CR;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    phase_bytes.push_back(b);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sld_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            kind_seen[kind]++;
            if (deframed_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", kind, 0);
            end
            else
            begin
                want = deframed_q.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (data_byte !== want.data_byte)
                    report_mismatch("data_byte", data_byte, want.data_byte);
                if (last_of_step !== want.last_of_step)
                    report_mismatch("last_of_step", last_of_step, want.last_of_step);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            // One long hold-off while the sender keeps offering bytes.
            if (!hold_done && items_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else if ((cycle_count % 1500) < 300)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    stall_left = $urandom_range(1, 3);
                else if (roll < 23)
                    stall_left = $urandom_range(10, 40);
                else
                    stall_left = 0;
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left = stall_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results still pending.",
                     cycle_count, deframed_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : run
        stim_row_t row;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'd0;
        cfg_we    = 1'b0;
        cfg_index = sld_pkg::REG_MAX_PAYLOAD;
        cfg_data  = 32'd0;
        for (int k = 0; k < 8; k++)
            kind_seen[k] = 0;

        max_payload_q = sld_pkg::MAX_PAYLOAD_RESET;
        max_text_q    = sld_pkg::MAX_TEXT_RESET;
        magic_q       = sld_pkg::MAGIC_RESET;
        mode_q        = sld_pkg::M_IDLE;
        frame_len_q   = 16'd0;
        payload_cnt_q = 16'd0;
        line_cnt_q    = 12'd0;
        magic_ok_q    = 1'b1;

        // A line made only of a carriage return gives nothing.
        directed_rows.push_back(quiet_row(sld_pkg::CH_CR));
        directed_rows.push_back(quiet_row(sld_pkg::CH_LF));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_SECOND));
        directed_rows.push_back(quiet_row(8'h00));
        directed_rows.push_back(one_row(8'h00, sld_pkg::K_LEN_ZERO, 8'h00));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_SECOND));
        directed_rows.push_back(quiet_row(8'hFF));
        directed_rows.push_back(one_row(8'hFF, sld_pkg::K_LEN_BIG, 8'h00));
        // Broken sync pair, then a sync byte inside the line.
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(two_row(8'h00, sld_pkg::K_TEXT, sld_pkg::SYNC_FIRST,
                                        sld_pkg::K_TEXT, 8'h00));
        directed_rows.push_back(one_row(sld_pkg::SYNC_FIRST, sld_pkg::K_TEXT,
                                        sld_pkg::SYNC_FIRST));
        directed_rows.push_back(one_row(sld_pkg::CH_LF, sld_pkg::K_LINE_END, 8'h00));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_SECOND));
        directed_rows.push_back(quiet_row(8'h00));
        directed_rows.push_back(quiet_row(8'h04));
        directed_rows.push_back(one_row(sld_pkg::MAGIC_RESET[31:24], sld_pkg::K_PAYLOAD,
                                        sld_pkg::MAGIC_RESET[31:24]));
        directed_rows.push_back(one_row(sld_pkg::MAGIC_RESET[23:16], sld_pkg::K_PAYLOAD,
                                        sld_pkg::MAGIC_RESET[23:16]));
        directed_rows.push_back(one_row(sld_pkg::MAGIC_RESET[15:8], sld_pkg::K_PAYLOAD,
                                        sld_pkg::MAGIC_RESET[15:8]));
        directed_rows.push_back(two_row(sld_pkg::MAGIC_RESET[7:0], sld_pkg::K_PAYLOAD,
                                        sld_pkg::MAGIC_RESET[7:0],
                                        sld_pkg::K_ACCEPT, 8'h00));
        // A one-byte frame is always rejected.
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_SECOND));
        directed_rows.push_back(quiet_row(8'h00));
        directed_rows.push_back(quiet_row(8'h01));
        directed_rows.push_back(two_row(8'hFF, sld_pkg::K_PAYLOAD, 8'hFF,
                                        sld_pkg::K_REJECT, 8'h00));
        directed_rows.push_back(cfg_row(sld_pkg::REG_MAX_TEXT, 32'd1));
        directed_rows.push_back(one_row(8'h78, sld_pkg::K_TEXT, 8'h78));
        directed_rows.push_back(one_row(8'h79, sld_pkg::K_LINE_OVF, 8'h00));
        // The held sync byte fills the line and the byte after it overflows.
        directed_rows.push_back(quiet_row(sld_pkg::SYNC_FIRST));
        directed_rows.push_back(two_row(8'h42, sld_pkg::K_TEXT, sld_pkg::SYNC_FIRST,
                                        sld_pkg::K_LINE_OVF, 8'h00));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                wait_idle();
                write_register(row.reg_idx, row.value);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_item(row);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       apply_setting(16'd4, 12'd1, 32'h0000_0000);
                1:       apply_setting(16'hFFFF, 12'hFFF, 32'hFFFF_FFFF);
                2:       apply_setting(16'd16, 12'd8, $urandom);
                3:       apply_setting(16'($urandom_range(1, 40)), 12'($urandom_range(1, 30)),
                                       $urandom);
                4:       apply_setting(16'd1, 12'd3, $urandom);
                default: apply_setting(sld_pkg::MAX_PAYLOAD_RESET, sld_pkg::MAX_TEXT_RESET,
                                       sld_pkg::MAGIC_RESET);
            endcase
            sender_gaps = (p != 1 && p != 4);
            build_phase_bytes();
            foreach (phase_bytes[i])
            begin
                row = '0;
                row.from_model = 1'b1;
                row.value      = {24'd0, phase_bytes[i]};
                send_item(row);
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);

        $display("Sent %0d bytes and checked %0d results across %0d register settings.",
                 items_sent, results_seen, settings_used);
        $display("Frames accepted %0d, rejected %0d; length errors %0d; lines %0d, overflows %0d.",
                 kind_seen[sld_pkg::K_ACCEPT], kind_seen[sld_pkg::K_REJECT],
                 kind_seen[sld_pkg::K_LEN_ZERO] + kind_seen[sld_pkg::K_LEN_BIG],
                 kind_seen[sld_pkg::K_LINE_END], kind_seen[sld_pkg::K_LINE_OVF]);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
